/* src/bcvp_pkg.sv */
package bcvp_pkg;

    localparam int VALUE_STORE_BYTES_DEF = 32;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int EX_W     = 20;
    localparam int EX_SAT   = 100000;
    localparam int E_W      = 22;
    localparam int DEC_INF  = 39;
    localparam int DEC_TINY = -46;
    localparam int BP_MIN   = -126;
    localparam int BP_MAX   = 127;
    localparam int EXP_BIAS = 127;
    localparam int MANT_W   = 23;
    localparam int Q_W      = 25;
    localparam int ITER_W   = 5;
    localparam int TEN_LOG2_MAX = 127;
    localparam int TINY_DIGITS  = 45;

    typedef struct packed {
        logic ld_cmd;
        logic clr_val;
        logic mdig;
        logic fdig;
        logic edig;
        logic set_sign;
        logic set_esign;
        logic setup;
        logic scale;
        logic norm;
        logic cmp;
        logic div;
        logic emit_round;
        logic emit_short;
    } cmd_t;

    typedef struct packed {
        logic short_hit;
        logic scale_done;
        logic norm_done;
        logic t_neg;
        logic div_last;
        logic out_free;
    } st_t;

endpackage

/* src/bcvp_ctrl.sv */
module bcvp_ctrl #(
    parameter int VALUE_STORE_BYTES = bcvp_pkg::VALUE_STORE_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [7:0]       s_rx_byte,
    output logic             s_ready,
    input  bcvp_pkg::st_t    st,
    output bcvp_pkg::cmd_t   cmd
);

    localparam int CNT_W = $clog2(VALUE_STORE_BYTES);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(VALUE_STORE_BYTES - 1);

    localparam logic [4:0] ST_HUNT     = 5'd0;
    localparam logic [4:0] ST_PRECMD   = 5'd1;
    localparam logic [4:0] ST_PRECOLON = 5'd2;
    localparam logic [4:0] ST_V_START  = 5'd3;
    localparam logic [4:0] ST_V_SIGN   = 5'd4;
    localparam logic [4:0] ST_V_INT    = 5'd5;
    localparam logic [4:0] ST_V_FRAC   = 5'd6;
    localparam logic [4:0] ST_V_EXP    = 5'd7;
    localparam logic [4:0] ST_V_ESIGN  = 5'd8;
    localparam logic [4:0] ST_V_EDIG   = 5'd9;
    localparam logic [4:0] ST_SETUP    = 5'd10;
    localparam logic [4:0] ST_SCALE    = 5'd11;
    localparam logic [4:0] ST_NORM     = 5'd12;
    localparam logic [4:0] ST_CMP      = 5'd13;
    localparam logic [4:0] ST_DIV      = 5'd14;
    localparam logic [4:0] ST_FINISH   = 5'd15;
    localparam logic [4:0] ST_SHORT    = 5'd16;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             has_dig_reg, has_dig_next;

    logic take, is_ws, is_dig, is_sgn, is_dot, is_ech, is_kept, end_ok;

    always_comb begin
        is_ws   = (s_rx_byte == bcvp_pkg::CH_SPACE) || (s_rx_byte == bcvp_pkg::CH_TAB) ||
                  (s_rx_byte == bcvp_pkg::CH_CR) || (s_rx_byte == bcvp_pkg::CH_LF);
        is_dig  = (s_rx_byte >= bcvp_pkg::CH_ZERO) && (s_rx_byte <= bcvp_pkg::CH_NINE);
        is_sgn  = (s_rx_byte == bcvp_pkg::CH_PLUS) || (s_rx_byte == bcvp_pkg::CH_MINUS);
        is_dot  = (s_rx_byte == bcvp_pkg::CH_DOT);
        is_ech  = (s_rx_byte == bcvp_pkg::CH_LOW_E) || (s_rx_byte == bcvp_pkg::CH_UP_E);
        is_kept = is_dig || is_sgn || is_dot || is_ech;
        end_ok  = (state_reg == ST_V_INT) || (state_reg == ST_V_EDIG) ||
                  ((state_reg == ST_V_FRAC) && has_dig_reg);
        s_ready = (state_reg <= ST_V_EDIG);
        take    = s_valid && s_ready;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        has_dig_next = has_dig_reg;
        cmd          = '0;
        if (take) begin
            if (s_rx_byte == bcvp_pkg::CH_LBRACE) begin
                state_next = ST_PRECMD;
            end else begin
                unique case (state_reg)
                    ST_HUNT: begin
                    end
                    ST_PRECMD: begin
                        if (!is_ws) begin
                            if ((s_rx_byte == bcvp_pkg::CH_RBRACE) ||
                                (s_rx_byte == bcvp_pkg::CH_COLON) ||
                                (s_rx_byte == bcvp_pkg::CH_NUL)) begin
                                state_next = ST_HUNT;
                            end else begin
                                cmd.ld_cmd = 1'b1;
                                state_next = ST_PRECOLON;
                            end
                        end
                    end
                    ST_PRECOLON: begin
                        if (!is_ws) begin
                            if (s_rx_byte == bcvp_pkg::CH_COLON) begin
                                cmd.clr_val  = 1'b1;
                                count_next   = '0;
                                has_dig_next = 1'b0;
                                state_next   = ST_V_START;
                            end else begin
                                state_next = ST_HUNT;
                            end
                        end
                    end
                    default: begin
                        if (!is_ws) begin
                            if (s_rx_byte == bcvp_pkg::CH_RBRACE) begin
                                state_next = end_ok ? ST_SETUP : ST_HUNT;
                            end else if (!is_kept || (count_reg == CNT_CAP)) begin
                                state_next = ST_HUNT;
                            end else begin
                                count_next = count_reg + 1'b1;
                                state_next = ST_HUNT;
                                unique case (state_reg)
                                    ST_V_START, ST_V_SIGN: begin
                                        if (is_sgn && (state_reg == ST_V_START)) begin
                                            cmd.set_sign = 1'b1;
                                            state_next   = ST_V_SIGN;
                                        end else if (is_dig) begin
                                            cmd.mdig     = 1'b1;
                                            has_dig_next = 1'b1;
                                            state_next   = ST_V_INT;
                                        end else if (is_dot) begin
                                            state_next = ST_V_FRAC;
                                        end
                                    end
                                    ST_V_INT: begin
                                        if (is_dig) begin
                                            cmd.mdig   = 1'b1;
                                            state_next = ST_V_INT;
                                        end else if (is_dot) begin
                                            state_next = ST_V_FRAC;
                                        end else if (is_ech) begin
                                            state_next = ST_V_EXP;
                                        end
                                    end
                                    ST_V_FRAC: begin
                                        if (is_dig) begin
                                            cmd.mdig     = 1'b1;
                                            cmd.fdig     = 1'b1;
                                            has_dig_next = 1'b1;
                                            state_next   = ST_V_FRAC;
                                        end else if (is_ech && has_dig_reg) begin
                                            state_next = ST_V_EXP;
                                        end
                                    end
                                    ST_V_EXP: begin
                                        if (is_sgn) begin
                                            cmd.set_esign = 1'b1;
                                            state_next    = ST_V_ESIGN;
                                        end else if (is_dig) begin
                                            cmd.edig   = 1'b1;
                                            state_next = ST_V_EDIG;
                                        end
                                    end
                                    default: begin
                                        if (is_dig) begin
                                            cmd.edig   = 1'b1;
                                            state_next = ST_V_EDIG;
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                endcase
            end
        end else begin
            unique case (state_reg)
                ST_SETUP: begin
                    cmd.setup  = 1'b1;
                    state_next = st.short_hit ? ST_SHORT : ST_SCALE;
                end
                ST_SCALE: begin
                    if (st.scale_done) begin
                        state_next = ST_NORM;
                    end else begin
                        cmd.scale = 1'b1;
                    end
                end
                ST_NORM: begin
                    if (st.norm_done) begin
                        state_next = ST_CMP;
                    end else begin
                        cmd.norm = 1'b1;
                    end
                end
                ST_CMP: begin
                    cmd.cmp    = 1'b1;
                    state_next = st.t_neg ? ST_FINISH : ST_DIV;
                end
                ST_DIV: begin
                    cmd.div = 1'b1;
                    if (st.div_last) begin
                        state_next = ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (st.out_free) begin
                        cmd.emit_round = 1'b1;
                        state_next     = ST_HUNT;
                    end
                end
                ST_SHORT: begin
                    if (st.out_free) begin
                        cmd.emit_short = 1'b1;
                        state_next     = ST_HUNT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HUNT;
            count_reg   <= '0;
            has_dig_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            has_dig_reg <= has_dig_next;
        end
    end

endmodule

/* src/bcvp_dp.sv */
module bcvp_dp #(
    parameter int VALUE_STORE_BYTES = bcvp_pkg::VALUE_STORE_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       s_rx_byte,
    input  bcvp_pkg::cmd_t   cmd,
    output bcvp_pkg::st_t    st,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_command,
    output logic [31:0]      m_value_bits
);

    localparam int CNT_W  = $clog2(VALUE_STORE_BYTES);
    localparam int NUM_W  = (VALUE_STORE_BYTES - 1) * 10 / 3 + 1;
    localparam int A_W    = NUM_W + bcvp_pkg::TEN_LOG2_MAX;
    localparam int B_W    = (VALUE_STORE_BYTES + bcvp_pkg::TINY_DIGITS - 1) * 10 / 3 + 2;
    localparam int W      = (A_W > B_W) ? A_W : B_W;
    localparam int K_W    = $clog2(VALUE_STORE_BYTES + bcvp_pkg::TINY_DIGITS);
    localparam int NRM_W  = $clog2(W + 1);
    localparam int L_W    = NRM_W + 3;
    localparam int E_W    = bcvp_pkg::E_W;
    localparam int EX_W   = bcvp_pkg::EX_W;
    localparam int Q_W    = bcvp_pkg::Q_W;
    localparam int IT_W   = bcvp_pkg::ITER_W;

    localparam logic signed [E_W-1:0] E_INF  = E_W'(bcvp_pkg::DEC_INF);
    localparam logic signed [E_W-1:0] E_TINY = E_W'(bcvp_pkg::DEC_TINY);
    localparam logic signed [L_W-1:0] BP_LO  = L_W'(bcvp_pkg::BP_MIN);
    localparam logic signed [L_W-1:0] BP_HI  = L_W'(bcvp_pkg::BP_MAX);
    localparam logic signed [L_W-1:0] BIAS_L = L_W'(bcvp_pkg::EXP_BIAS);
    localparam logic signed [L_W-1:0] Q_TOP  = L_W'(Q_W - 1);
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;

    logic [7:0]       cmd_reg, cmd_next;
    logic             neg_reg, neg_next, eneg_reg, eneg_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [CNT_W-1:0] nd_reg, nd_next, frac_reg, frac_next;
    logic [EX_W-1:0]  ex_reg, ex_next;
    logic [W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             epos_reg, epos_next;
    logic [NRM_W-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [W:0]       r_reg, r_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic signed [L_W-1:0] bp_reg, bp_next;
    logic [IT_W-1:0]  iter_reg, iter_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_cmd_reg, m_cmd_next;
    logic [31:0]      m_bits_reg, m_bits_next;

    logic [3:0]            dig;
    logic signed [E_W-1:0] ex_s, e_val, abs_e, nd_e;
    logic                  num_zero;
    logic signed [L_W-1:0] l_val, e_bin, bp_val, t_val, bpf, exp_sum;
    logic                  r_ge, carry, inc;
    logic [W:0]            r_sub;
    logic [Q_W-2:0]        mant;
    logic [Q_W-1:0]        m1;
    logic [Q_W-2:0]        mfin;
    logic [31:0]           round_bits, short_bits;

    always_comb begin
        dig      = s_rx_byte[3:0];
        num_zero = (num_reg == '0);
        ex_s     = $signed({{(E_W - EX_W){1'b0}}, ex_reg});
        e_val    = (eneg_reg ? -ex_s : ex_s) - $signed({{(E_W - CNT_W){1'b0}}, frac_reg});
        abs_e    = (e_val < 0) ? -e_val : e_val;
        nd_e     = $signed({{(E_W - CNT_W){1'b0}}, nd_reg}) + e_val;

        st.short_hit  = num_zero || (e_val >= E_INF) || (nd_e <= E_TINY);
        st.scale_done = (k_reg == '0);
        st.norm_done  = a_reg[W-1] && b_reg[W-1];

        l_val  = $signed({{(L_W - NRM_W){1'b0}}, cb_reg}) -
                 $signed({{(L_W - NRM_W){1'b0}}, ca_reg});
        e_bin  = (a_reg >= b_reg) ? l_val : l_val - L_W'(1);
        bp_val = (e_bin < BP_LO) ? BP_LO : e_bin;
        t_val  = l_val + Q_TOP - bp_val;
        st.t_neg    = (t_val < 0);
        st.div_last = (iter_reg == '0);
        st.out_free = !m_valid_reg || m_ready;

        r_ge  = (r_reg >= {1'b0, b_reg});
        r_sub = r_ge ? r_reg - {1'b0, b_reg} : r_reg;

        mant    = q_reg[Q_W-1:1];
        inc     = q_reg[0] && ((r_reg != '0) || mant[0]);
        m1      = {1'b0, mant} + {{(Q_W - 1){1'b0}}, inc};
        carry   = m1[Q_W-1];
        mfin    = carry ? m1[Q_W-1:1] : m1[Q_W-2:0];
        bpf     = bp_reg + $signed({{(L_W - 1){1'b0}}, carry});
        exp_sum = bpf + BIAS_L;
        if (bpf > BP_HI) begin
            round_bits = {neg_reg, INF_BITS[30:0]};
        end else if (mfin[Q_W-2]) begin
            round_bits = {neg_reg, exp_sum[7:0], mfin[bcvp_pkg::MANT_W-1:0]};
        end else begin
            round_bits = {neg_reg, 8'h00, mfin[bcvp_pkg::MANT_W-1:0]};
        end
        if (!num_zero && (e_val >= E_INF)) begin
            short_bits = {neg_reg, INF_BITS[30:0]};
        end else begin
            short_bits = {neg_reg, 31'h0};
        end
    end

    always_comb begin
        cmd_next     = cmd_reg;
        neg_next     = neg_reg;
        eneg_next    = eneg_reg;
        num_next     = num_reg;
        nd_next      = nd_reg;
        frac_next    = frac_reg;
        ex_next      = ex_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        epos_next    = epos_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        bp_next      = bp_reg;
        iter_next    = iter_reg;
        m_cmd_next   = m_cmd_reg;
        m_bits_next  = m_bits_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cmd.ld_cmd) begin
            cmd_next = s_rx_byte;
        end
        if (cmd.clr_val) begin
            neg_next  = 1'b0;
            eneg_next = 1'b0;
            num_next  = '0;
            nd_next   = '0;
            frac_next = '0;
            ex_next   = '0;
        end
        if (cmd.set_sign) begin
            neg_next = (s_rx_byte == bcvp_pkg::CH_MINUS);
        end
        if (cmd.set_esign) begin
            eneg_next = (s_rx_byte == bcvp_pkg::CH_MINUS);
        end
        if (cmd.mdig) begin
            num_next = {num_reg[NUM_W-4:0], 3'b000} + {num_reg[NUM_W-2:0], 1'b0} +
                       {{(NUM_W - 4){1'b0}}, dig};
            nd_next  = nd_reg + 1'b1;
        end
        if (cmd.fdig) begin
            frac_next = frac_reg + 1'b1;
        end
        if (cmd.edig && (ex_reg < EX_W'(bcvp_pkg::EX_SAT))) begin
            ex_next = {ex_reg[EX_W-4:0], 3'b000} + {ex_reg[EX_W-2:0], 1'b0} +
                      {{(EX_W - 4){1'b0}}, dig};
        end
        if (cmd.setup) begin
            a_next    = {{(W - NUM_W){1'b0}}, num_reg};
            b_next    = {{(W - 1){1'b0}}, 1'b1};
            k_next    = abs_e[K_W-1:0];
            epos_next = (e_val >= 0);
            ca_next   = '0;
            cb_next   = '0;
        end
        if (cmd.scale) begin
            if (epos_reg) begin
                a_next = {a_reg[W-4:0], 3'b000} + {a_reg[W-2:0], 1'b0};
            end else begin
                b_next = {b_reg[W-4:0], 3'b000} + {b_reg[W-2:0], 1'b0};
            end
            k_next = k_reg - 1'b1;
        end
        if (cmd.norm) begin
            if (a_reg[W-1 -: 16] == '0) begin
                a_next  = {a_reg[W-17:0], 16'h0000};
                ca_next = ca_reg + NRM_W'(16);
            end else if (!a_reg[W-1]) begin
                a_next  = {a_reg[W-2:0], 1'b0};
                ca_next = ca_reg + 1'b1;
            end
            if (b_reg[W-1 -: 16] == '0) begin
                b_next  = {b_reg[W-17:0], 16'h0000};
                cb_next = cb_reg + NRM_W'(16);
            end else if (!b_reg[W-1]) begin
                b_next  = {b_reg[W-2:0], 1'b0};
                cb_next = cb_reg + 1'b1;
            end
        end
        if (cmd.cmp) begin
            r_next    = {1'b0, a_reg};
            q_next    = '0;
            bp_next   = bp_val;
            iter_next = t_val[IT_W-1:0];
        end
        if (cmd.div) begin
            r_next    = {r_sub[W-1:0], 1'b0};
            q_next    = {q_reg[Q_W-2:0], r_ge};
            iter_next = iter_reg - 1'b1;
        end
        if (cmd.emit_round || cmd.emit_short) begin
            m_valid_next = 1'b1;
            m_cmd_next   = cmd_reg;
            m_bits_next  = cmd.emit_round ? round_bits : short_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        eneg_reg   <= eneg_next;
        num_reg    <= num_next;
        nd_reg     <= nd_next;
        frac_reg   <= frac_next;
        ex_reg     <= ex_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        epos_reg   <= epos_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        bp_reg     <= bp_next;
        iter_reg   <= iter_next;
        m_cmd_reg  <= m_cmd_next;
        m_bits_reg <= m_bits_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_command    = m_cmd_reg;
    assign m_value_bits = m_bits_reg;

endmodule

/* src/brace_command_value_parser.sv */
// Frame parser for "{C:value}" commands on a received byte stream.
// Input channel s_valid/s_ready/s_rx_byte takes one character per transaction;
// result channel m_valid/m_ready carries m_command and m_value_bits (binary32).
// While a frame is being assembled a byte is taken every cycle: syntax is
// checked and the decimal mantissa and exponent are accumulated on the fly.
// The closing brace of a good frame starts the conversion, during which
// s_ready is low. It scales by the decimal exponent |e| (up to 76), one
// multiply by ten per cycle, which dominates; normalises both operands (a
// 16-bit or 1-bit shift per cycle); and runs up to 26 restoring-division
// steps. Zero, overflow and underflow shortcuts skip scaling, normalisation
// and division. The result lands in an output register; bytes are still
// taken while it waits. If the next result is ready before the receiver
// takes the previous one, the block holds with s_ready low. Reset
// (synchronous, active low) returns to hunting for an opening brace with
// no result pending.
module brace_command_value_parser #(
    parameter int VALUE_STORE_BYTES = bcvp_pkg::VALUE_STORE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_command,
    output logic [31:0] m_value_bits
);

    bcvp_pkg::cmd_t cmd;
    bcvp_pkg::st_t  st;

    bcvp_ctrl #(
        .VALUE_STORE_BYTES(VALUE_STORE_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_rx_byte (s_rx_byte),
        .s_ready   (s_ready),
        .st        (st),
        .cmd       (cmd)
    );

    bcvp_dp #(
        .VALUE_STORE_BYTES(VALUE_STORE_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_rx_byte    (s_rx_byte),
        .cmd          (cmd),
        .st           (st),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_value_bits (m_value_bits)
    );

`ifndef SYNTH
    a_no_byte_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.scale || cmd.norm || cmd.cmp || cmd.div))
        else $error("conversion step while taking bytes");

    a_one_conv_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.setup, cmd.scale, cmd.norm, cmd.cmp, cmd.div,
                  cmd.emit_round, cmd.emit_short}))
        else $error("more than one conversion step at once");

    a_div_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div && st.div_last) |=> !cmd.div)
        else $error("division ran past its last step");

    a_byte_cmds_on_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ld_cmd || cmd.clr_val || cmd.mdig || cmd.edig) |-> (s_valid && s_ready))
        else $error("byte command without input transaction");
`endif

endmodule

/* verif/bcvp_checker.sv */
`timescale 1ns / 1ps

module bcvp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_command,
    input  logic [31:0] m_value_bits,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    typedef logic [511:0] big_t;
    typedef enum logic [1:0] {HUNT, PRECMD, PRECOLON, VALUE} frame_phase_t;

    typedef struct {
        logic [7:0]  command;
        logic [31:0] bits;
    } frame_result_t;

    frame_result_t awaited_q[$];

    frame_phase_t phase;
    logic [7:0]   held_cmd;
    logic [7:0]   chars [31];
    int           n_chars;

    function automatic bit is_space(logic [7:0] c);
        return c == bcvp_pkg::CH_SPACE || c == bcvp_pkg::CH_TAB || c == bcvp_pkg::CH_CR
               || c == bcvp_pkg::CH_LF;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= bcvp_pkg::CH_ZERO && c <= bcvp_pkg::CH_NINE;
    endfunction

    function automatic bit is_sign(logic [7:0] c);
        return c == bcvp_pkg::CH_PLUS || c == bcvp_pkg::CH_MINUS;
    endfunction

    function automatic int bit_length(big_t v);
        for (int k = 511; k >= 0; k--) begin
            if (v[k]) return k + 1;
        end
        return 0;
    endfunction

    function automatic int scaled_quotient(big_t num, big_t den, int b, output logic [31:0] q,
                                           output bit sticky);
        int   bp;
        int   sh;
        big_t a;
        big_t d;
        bp = b < bcvp_pkg::BP_MIN ? bcvp_pkg::BP_MIN : b;
        sh = 24 - bp;
        if (sh >= 0) begin
            a = num << sh;
            d = den;
        end else begin
            a = num;
            d = den << (-sh);
        end
        q = 32'(a / d);
        sticky = (a % d) != 0;
        return bp;
    endfunction

    function automatic bit decimal_to_binary32(int n, output logic [31:0] bits);
        int          i;
        int          nd;
        int          frac;
        int          ex;
        int          ed;
        int          e;
        int          l;
        int          bp;
        bit          neg;
        bit          eneg;
        bit          sticky;
        logic [31:0] sign;
        logic [31:0] q;
        logic [31:0] mant;
        big_t        num;
        big_t        den;
        i = 0; nd = 0; frac = 0; ex = 0; neg = 0; eneg = 0; num = '0; bits = '0;
        if (i < n && is_sign(chars[i])) begin
            neg = chars[i] == bcvp_pkg::CH_MINUS;
            i++;
        end
        while (i < n && is_digit(chars[i])) begin
            num = num * 10 + (chars[i] - bcvp_pkg::CH_ZERO);
            nd++; i++;
        end
        if (i < n && chars[i] == bcvp_pkg::CH_DOT) begin
            i++;
            while (i < n && is_digit(chars[i])) begin
                num = num * 10 + (chars[i] - bcvp_pkg::CH_ZERO);
                nd++; frac++; i++;
            end
        end
        if (nd == 0) return 0;
        if (i < n && (chars[i] == bcvp_pkg::CH_LOW_E || chars[i] == bcvp_pkg::CH_UP_E)) begin
            ed = 0;
            i++;
            if (i < n && is_sign(chars[i])) begin
                eneg = chars[i] == bcvp_pkg::CH_MINUS;
                i++;
            end
            while (i < n && is_digit(chars[i])) begin
                if (ex < bcvp_pkg::EX_SAT) ex = ex * 10 + int'(chars[i] - bcvp_pkg::CH_ZERO);
                ed++; i++;
            end
            if (ed == 0) return 0;
        end
        if (i != n) return 0;

        sign = neg ? 32'h8000_0000 : 32'h0;
        e = (eneg ? -ex : ex) - frac;
        if (num == 0) begin
            bits = sign;
            return 1;
        end
        if (e >= bcvp_pkg::DEC_INF) begin
            bits = sign | 32'h7F80_0000;
            return 1;
        end
        if (nd + e <= bcvp_pkg::DEC_TINY) begin
            bits = sign;
            return 1;
        end
        den = 1;
        for (int k = 0; k < e; k++) num = num * 10;
        for (int k = 0; k < -e; k++) den = den * 10;
        l = bit_length(num) - bit_length(den);
        bp = scaled_quotient(num, den, l, q, sticky);
        if (l > bcvp_pkg::BP_MIN && q < (32'd1 << 24)) begin
            bp = scaled_quotient(num, den, l - 1, q, sticky);
        end
        mant = q >> 1;
        if (q[0] && (sticky || mant[0])) mant++;
        if (mant == (32'd1 << 24)) begin
            mant >>= 1;
            bp++;
        end
        if (bp > bcvp_pkg::BP_MAX) bits = sign | 32'h7F80_0000;
        else if (mant >= (32'd1 << bcvp_pkg::MANT_W))
            bits = sign | (32'(bp + bcvp_pkg::EXP_BIAS) << bcvp_pkg::MANT_W)
                   | (mant & 32'h7F_FFFF);
        else bits = sign | mant;
        return 1;
    endfunction

    task automatic parse_byte(logic [7:0] c);
        logic [31:0] bits;
        if (c == bcvp_pkg::CH_LBRACE) begin
            phase = PRECMD;
            return;
        end
        case (phase)
            HUNT: ;
            PRECMD: begin
                if (!is_space(c)) begin
                    if (c == bcvp_pkg::CH_RBRACE || c == bcvp_pkg::CH_COLON
                        || c == bcvp_pkg::CH_NUL) begin
                        phase = HUNT;
                    end else begin
                        held_cmd = c;
                        phase = PRECOLON;
                    end
                end
            end
            PRECOLON: begin
                if (!is_space(c)) begin
                    if (c == bcvp_pkg::CH_COLON) begin
                        n_chars = 0;
                        phase = VALUE;
                    end else begin
                        phase = HUNT;
                    end
                end
            end
            VALUE: begin
                if (is_space(c)) begin
                end else if (c == bcvp_pkg::CH_RBRACE) begin
                    phase = HUNT;
                    if (decimal_to_binary32(n_chars, bits)) awaited_q.push_back('{held_cmd, bits});
                end else if (is_digit(c) || is_sign(c) || c == bcvp_pkg::CH_DOT
                             || c == bcvp_pkg::CH_LOW_E || c == bcvp_pkg::CH_UP_E) begin
                    if (n_chars < bcvp_pkg::VALUE_STORE_BYTES_DEF - 1) chars[n_chars++] = c;
                    else phase = HUNT;
                end else begin
                    phase = HUNT;
                end
            end
            default: phase = HUNT;
        endcase
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            phase = HUNT;
            held_cmd = '0;
            n_chars = 0;
            awaited_q.delete();
            errors = 0;
            results_seen = 0;
        end else begin
            if (s_valid && s_ready) parse_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_q.size() == 0) begin
                    errors++;
                    $error("unexpected result: command %h value_bits %h", m_command, m_value_bits);
                end else begin
                    want = awaited_q.pop_front();
                    if (m_command !== want.command) begin
                        errors++;
                        $error("command: expected %h actual %h", want.command, m_command);
                    end
                    if (m_value_bits !== want.bits) begin
                        errors++;
                        $error("value_bits: expected %h actual %h", want.bits, m_value_bits);
                    end
                end
            end
        end
        pending = awaited_q.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_command;
    logic [31:0] m_value_bits;

    int errors;
    int pending;
    int results_seen;
    int bytes_sent;
    int burst_left;
    bit hold_off;
    int rx_mode;
    int rx_cycles;

    brace_command_value_parser u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_value_bits (m_value_bits)
    );

    bcvp_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_value_bits (m_value_bits),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // receiver: switch among three stall patterns
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode <= 0;
            rx_cycles <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles % 300 == 0) rx_mode <= $urandom_range(0, 2);
            if (hold_off) m_ready <= 1'b0;
            else case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (bytes_sent >= 500);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (2000) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("brace_command_value_parser: mismatch");
        $finish;
    end

    task automatic put_byte(logic [7:0] b);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    task automatic put_text(string t);
        for (int k = 0; k < t.len(); k++) put_byte(t[k]);
    endtask

    task automatic put_space();
        logic [7:0] sp [4];
        sp = '{bcvp_pkg::CH_SPACE, bcvp_pkg::CH_TAB, bcvp_pkg::CH_CR, bcvp_pkg::CH_LF};
        if ($urandom_range(0, 5) == 0) put_byte(sp[$urandom_range(0, 3)]);
    endtask

    task automatic put_digits(int n);
        for (int k = 0; k < n; k++) begin
            put_byte(bcvp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            put_space();
        end
    endtask

    task automatic put_frame();
        logic [7:0] cmd;
        int         nint;
        int         nfrac;
        do cmd = 8'($urandom_range(1, 255));
        while (cmd == bcvp_pkg::CH_LBRACE || cmd == bcvp_pkg::CH_RBRACE
               || cmd == bcvp_pkg::CH_COLON || cmd == bcvp_pkg::CH_SPACE
               || cmd == bcvp_pkg::CH_TAB || cmd == bcvp_pkg::CH_CR || cmd == bcvp_pkg::CH_LF);
        put_byte(bcvp_pkg::CH_LBRACE);
        put_space();
        put_byte(cmd);
        put_space();
        put_byte(bcvp_pkg::CH_COLON);
        put_space();
        case ($urandom_range(0, 2))
            0: put_byte(bcvp_pkg::CH_PLUS);
            1: put_byte(bcvp_pkg::CH_MINUS);
            default: ;
        endcase
        nint = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
        nfrac = $urandom_range(0, 1) ? $urandom_range(0, 8) : 0;
        if (nint == 0 && nfrac == 0 && $urandom_range(0, 9) != 0) nint = 1;
        put_digits(nint);
        if (nfrac > 0 || $urandom_range(0, 7) == 0) put_byte(bcvp_pkg::CH_DOT);
        put_digits(nfrac);
        if ($urandom_range(0, 1)) begin
            put_byte($urandom_range(0, 1) ? bcvp_pkg::CH_LOW_E : bcvp_pkg::CH_UP_E);
            case ($urandom_range(0, 2))
                0: put_byte(bcvp_pkg::CH_PLUS);
                1: put_byte(bcvp_pkg::CH_MINUS);
                default: ;
            endcase
            put_digits($urandom_range(0, 6) == 0 ? $urandom_range(0, 4) : $urandom_range(1, 2));
        end
        put_space();
        if ($urandom_range(0, 19) != 0) put_byte(bcvp_pkg::CH_RBRACE);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        bytes_sent = 0;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_text("xx}{A:0}");
        put_text("{ B : -0 }");
        put_text("{x:3.4028235e38}{y:-1e39}{z:1e-46}{q:1.4e-45}");
        put_text("{c:+1.5E+2}{d:.5}{e:5.}{f:1.17549435e-38}");
        put_text("{g:1234567890123456789012345678901}");
        put_text("{h:12345678901234567890123456789012}");
        put_text("{}{:1}{a b:1}{a:1x}{a:}{a:e5}{a:1e}{a:1..2}{a:--1}{a:{b:2}");
        put_byte(bcvp_pkg::CH_LBRACE);
        put_byte(bcvp_pkg::CH_NUL);
        put_text("{k:1");
        put_byte(bcvp_pkg::CH_NUL);
        put_text("}{m:1e99999999}{n:0.000e-99999}");
        s_valid <= 1'b0;
        wait (pending == 0);
        @(posedge aclk);

        while (bytes_sent < 1000) begin
            if ($urandom_range(0, 9) < 8) put_frame();
            else repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            if (bytes_sent > 700 && bytes_sent < 760) begin
                s_valid <= 1'b0;
                wait (pending == 0);
                @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (300) @(posedge aclk);
        $display("Sent %0d bytes of frames, broken frames and noise; %0d results checked.",
                 bytes_sent, results_seen);
        if (errors == 0 && pending == 0) begin
            $display("brace_command_value_parser: match");
        end else begin
            $display("brace_command_value_parser: mismatch");
        end
        $finish;
    end

endmodule
